[sv/aldc_pkg.sv]
// aldc_pkg: shared constants, types and the register map of the level change detector.
// No dependencies.
package aldc_pkg;
  localparam int MaxBufferWords = 4096;
  localparam int BwW = $clog2(MaxBufferWords + 1);
  localparam int BsW = 16 + BwW;
  localparam int TwW = 18;
  localparam int TsW = 40;
  localparam int TqW = 50;
  localparam int QDepth = 2;

  localparam logic [1:0] REG_TRAIN = 2'd0;
  localparam logic [1:0] REG_THRESH = 2'd1;
  localparam logic [1:0] REG_DUR = 2'd2;

  // one closed buffer, handed from the front to the back
  typedef struct packed {
    logic          trains;
    logic          fix;
    logic [BsW-1:0] sum;
    logic [BwW-1:0] words;
    logic [31:0]   step;
    logic [31:0]   total;
  } job_t;
endpackage

[sv/aldc_front.sv]
// aldc_front: accepts words, keeps buffer and training accumulators, emits one job per buffer.
// Depends on aldc_pkg.
module aldc_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [15:0]             word,
  input  logic                    last,
  input  logic [31:0]             step,
  input  logic [31:0]             total,
  input  logic [15:0]             training_count,
  input  logic                    trained,
  output logic                    job_valid,
  input  logic                    job_ready,
  output aldc_pkg::job_t          job,
  output logic [aldc_pkg::TsW-1:0] train_sum,
  output logic [aldc_pkg::TqW-1:0] train_sq,
  output logic [aldc_pkg::TwW-1:0] train_words
);
  import aldc_pkg::*;
  logic           active_r, trains_r, fix_r;
  logic [BsW-1:0] bsum_r;
  logic [BwW-1:0] bwords_r;
  logic [TsW-1:0] tsum_r;
  logic [TqW-1:0] tsq_r;
  logic [TwW-1:0] tw_r;
  logic           start_trains, start_fix, cur_trains, cur_fix, close;
  logic [BsW-1:0] sum_nxt;
  logic [BwW-1:0] words_nxt;
  logic [31:0]    sq;

  // the back reads the training sums at a fix job, so hold the front while a job waits
  assign in_ready = !job_valid || job_ready;
  assign start_trains = !trained && ({2'b0, training_count} > tw_r);
  assign start_fix = !trained && !start_trains;
  assign cur_trains = active_r ? trains_r : start_trains;
  assign cur_fix = active_r ? fix_r : start_fix;
  assign sum_nxt = (active_r ? bsum_r : '0) + BsW'(word);
  assign words_nxt = (active_r ? bwords_r : '0) + BwW'(1);
  assign close = last || (words_nxt >= BwW'(MaxBufferWords));
  assign sq = word * word;

  logic job_valid_r;
  job_t job_r;
  assign job_valid = job_valid_r;
  assign job = job_r;
  assign train_sum = tsum_r;
  assign train_sq = tsq_r;
  assign train_words = tw_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      trains_r <= 1'b0;
      fix_r <= 1'b0;
      tsum_r <= '0;
      tsq_r <= '0;
      tw_r <= '0;
      job_valid_r <= 1'b0;
    end else begin
      if (job_ready) job_valid_r <= 1'b0;
      if (in_valid && in_ready) begin
        bsum_r <= sum_nxt;
        bwords_r <= words_nxt;
        trains_r <= cur_trains;
        fix_r <= cur_fix;
        active_r <= !close;
        if (cur_trains) begin
          tsum_r <= tsum_r + TsW'(word);
          tsq_r <= tsq_r + TqW'(sq);
          tw_r <= tw_r + TwW'(1);
        end
        if (close) begin
          job_valid_r <= 1'b1;
          job_r.trains <= cur_trains;
          job_r.fix <= cur_fix;
          job_r.sum <= sum_nxt;
          job_r.words <= words_nxt;
          job_r.step <= step;
          job_r.total <= total;
        end
      end
    end
  end
endmodule

[sv/aldc_queue.sv]
// aldc_queue: short job queue between front and back.
// Depends on aldc_pkg.
module aldc_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  aldc_pkg::job_t wr_job,
  output logic           rd_valid,
  input  logic           rd_ready,
  output aldc_pkg::job_t rd_job
);
  import aldc_pkg::*;
  localparam int AW = $clog2(QDepth);
  job_t        mem_r [QDepth];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;
  logic wr, rd;
  assign wr_ready = cnt_r != (AW+1)'(QDepth);
  assign rd_valid = cnt_r != '0;
  assign rd_job = mem_r[rp_r];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;
  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_job;
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= wp_r + AW'(1);
      if (rd) rp_r <= rp_r + AW'(1);
      cnt_r <= cnt_r + (AW+1)'(wr) - (AW+1)'(rd);
    end
  end
endmodule

[sv/aldc_back.sv]
// aldc_back: fixes statistics, tests each buffer after training, computes event time, drives results.
// Depends on aldc_pkg.
module aldc_back (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     job_valid,
  output logic                     job_ready,
  input  aldc_pkg::job_t           job,
  input  logic [aldc_pkg::TsW-1:0] train_sum,
  input  logic [aldc_pkg::TqW-1:0] train_sq,
  input  logic [aldc_pkg::TwW-1:0] train_words,
  input  logic [19:0]              threshold,
  input  logic [31:0]              duration,
  output logic                     trained,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [33:0]              out_data
);
  import aldc_pkg::*;
  localparam logic [3:0] S_IDLE = 4'd0, S_MDIV = 4'd1, S_DEV = 4'd2, S_VDIV = 4'd3,
    S_SQRT = 4'd4, S_T1 = 4'd5, S_T2 = 4'd6, S_T3 = 4'd7, S_P1 = 4'd8,
    S_TDIV = 4'd9, S_OUT = 4'd10;
  localparam int DW = 64;

  logic [3:0]    st_r;
  job_t          j_r;
  logic          trained_r;
  logic [15:0]   mean_r, dev_r;
  logic [DW-1:0] num_r, quo_r, rem_r, den_r;
  logic [6:0]    cnt_r;
  logic [63:0]   a_r, b_r;
  logic [63:0]   root_r, bit_r, v_r;
  logic          event_r;
  logic [33:0]   od_r;
  logic          ov_r;
  logic [63:0]   rem_sh;
  logic [64:0]   rem_try;

  assign trained = trained_r;
  assign job_ready = st_r == S_IDLE;
  assign out_valid = ov_r;
  // result beat is held in its own register so the back can start the next job
  assign out_data = od_r;
  assign rem_sh = {rem_r[DW-2:0], num_r[DW-1]};
  assign rem_try = {1'b0, rem_sh} - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      trained_r <= 1'b0;
      mean_r <= '0;
      dev_r <= '0;
      ov_r <= 1'b0;
    end else begin
      if (out_ready) ov_r <= 1'b0;
      case (st_r)
        S_IDLE: begin
          if (job_valid) begin
            j_r <= job;
            event_r <= 1'b0;
            if (job.fix && train_words == '0) begin
              mean_r <= '0;
              dev_r <= '0;
              trained_r <= 1'b1;
              st_r <= S_T1;
            end else if (job.fix) begin
              num_r <= DW'(train_sum);
              den_r <= DW'(train_words);
              rem_r <= '0;
              cnt_r <= 7'(DW);
              st_r <= S_MDIV;
            end else if (job.trains) begin
              st_r <= S_OUT;
            end else begin
              st_r <= S_T1;
            end
          end
        end
        // shared restoring divider, one quotient bit per cycle
        S_MDIV, S_VDIV, S_TDIV: begin
          num_r <= {num_r[DW-2:0], 1'b0};
          if (!rem_try[64]) begin
            rem_r <= rem_try[63:0];
            quo_r <= {quo_r[DW-2:0], 1'b1};
          end else begin
            rem_r <= rem_sh;
            quo_r <= {quo_r[DW-2:0], 1'b0};
          end
          cnt_r <= cnt_r - 7'd1;
          if (cnt_r == 7'd1) begin
            case (st_r)
              S_MDIV: st_r <= S_DEV;
              S_VDIV: st_r <= S_SQRT;
              default: st_r <= S_OUT;
            endcase
          end
        end
        S_DEV: begin
          // sum sq - 2m*sum + n*m^2 == sq - m*(2*sum - n*m); m < 2^16 keeps products narrow
          mean_r <= quo_r[15:0];
          a_r <= 64'(quo_r[23:0]) * 64'(train_words);
          st_r <= S_P1;
          cnt_r <= 7'd0;
        end
        S_P1: begin
          if (cnt_r == 7'd0) begin
            a_r <= 64'({train_sum, 1'b0}) - a_r;
            cnt_r <= 7'd1;
          end else begin
            num_r <= 64'(train_sq) - 64'(a_r[47:0]) * 64'(quo_r[15:0]);
            den_r <= DW'(train_words);
            rem_r <= '0;
            cnt_r <= 7'(DW);
            st_r <= S_VDIV;
          end
        end
        S_SQRT: begin
          if (cnt_r == 7'd0) begin
            v_r <= quo_r;
            root_r <= '0;
            bit_r <= 64'h4000_0000_0000_0000;
            cnt_r <= 7'd1;
          end else if (bit_r == '0) begin
            dev_r <= root_r[15:0];
            trained_r <= 1'b1;
            st_r <= S_T1;
          end else begin
            if (v_r >= root_r + bit_r) begin
              v_r <= v_r - (root_r + bit_r);
              root_r <= (root_r >> 1) + bit_r;
            end else begin
              root_r <= root_r >> 1;
            end
            bit_r <= bit_r >> 2;
          end
        end
        S_T1: begin
          a_r <= 64'(mean_r) * 64'(j_r.words);
          b_r <= 64'(threshold) * 64'(dev_r);
          st_r <= S_T2;
        end
        S_T2: begin
          a_r <= (64'(j_r.sum) >= a_r) ? 64'(j_r.sum) - a_r : a_r - 64'(j_r.sum);
          b_r <= 64'(b_r[35:0]) * 64'(j_r.words);
          st_r <= S_T3;
        end
        S_T3: begin
          if ({a_r[47:0], 16'h0} > b_r) begin
            event_r <= 1'b1;
            if (j_r.total != '0) begin
              num_r <= 64'(j_r.step) * 64'(duration);
              den_r <= DW'(j_r.total);
              rem_r <= '0;
              cnt_r <= 7'(DW);
              st_r <= S_TDIV;
            end else begin
              st_r <= S_OUT;
            end
          end else begin
            st_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (!ov_r || out_ready) begin
            od_r <= {trained_r,
                     (event_r && j_r.total != '0) ?
                       ((quo_r[63:32] != '0) ? 32'hFFFF_FFFF : quo_r[31:0]) : 32'h0,
                     event_r};
            ov_r <= 1'b1;
            st_r <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule

[sv/audio_level_change_detector_top.sv]
// audio_level_change_detector_top: level change detector with stream ports and register port.
// Depends on aldc_pkg, aldc_front, aldc_queue, aldc_back.
//
// Input beats carry one 16-bit word; in_tlast closes a buffer (a buffer also closes at
// 4096 words). Each closed buffer gives one output beat: event flag, event time, trained.
// Buffers that start before training_count words are trained accumulate sum and square
// sum; the next buffer fixes mean and deviation, and it and later buffers are tested.
// Throughput: one word per cycle into the front while in_tready is high; a closed buffer
// waits in a two-entry queue for the back. The back sends a training buffer straight to
// its output state and runs a test buffer through T1, T2 and T3, then through the serial
// event-time divider on an event; the buffer that fixes the statistics first runs a mean
// divide, the deviation setup, a variance divide and a square root.
// Reset (rst_n low, synchronous) clears statistics, queue and registers to defaults.
// A stalled out_tready holds the result; the back then stops, the queue fills, and
// in_tready drops while a job cannot be handed on.
// Registers: 0x0 training_count, 0x4 threshold_q16, 0x8 track_duration.
module audio_level_change_detector_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,   // sample_word[15:0], progress_step[47:16], progress_total[79:48]
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // event_detected[0], event_time[32:1], trained[33], zero fill
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import aldc_pkg::*;
  logic [15:0] tc_r;
  logic [19:0] th_r;
  logic [31:0] du_r;
  logic        wr;
  logic [1:0]  ridx;

  assign cfg_pready = 1'b1;
  assign wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign ridx = cfg_paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tc_r <= 16'd1600;
      th_r <= 20'd20795;
      du_r <= '0;
    end else if (wr && cfg_paddr[1:0] == 2'b00) begin
      case (ridx)
        REG_TRAIN:  tc_r <= cfg_pwdata[15:0];
        REG_THRESH: th_r <= cfg_pwdata[19:0];
        REG_DUR:    du_r <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_TRAIN:  cfg_prdata = {16'h0, tc_r};
      REG_THRESH: cfg_prdata = {12'h0, th_r};
      REG_DUR:    cfg_prdata = du_r;
      default:    cfg_prdata = '0;
    endcase
  end

  logic           fj_valid, fj_ready, qj_valid, qj_ready, trained;
  job_t           fj, qj;
  logic [TsW-1:0] tsum;
  logic [TqW-1:0] tsq;
  logic [TwW-1:0] tw;
  logic [33:0]    res;

  aldc_front u_front (
    .clk, .rst_n,
    .in_valid(in_tvalid), .in_ready(in_tready),
    .word(in_tdata[15:0]), .last(in_tlast),
    .step(in_tdata[47:16]), .total(in_tdata[79:48]),
    .training_count(tc_r), .trained,
    .job_valid(fj_valid), .job_ready(fj_ready), .job(fj),
    .train_sum(tsum), .train_sq(tsq), .train_words(tw)
  );

  aldc_queue u_queue (
    .clk, .rst_n,
    .wr_valid(fj_valid), .wr_ready(fj_ready), .wr_job(fj),
    .rd_valid(qj_valid), .rd_ready(qj_ready), .rd_job(qj)
  );

  // trained is read by the front at buffer start; training sums stay fixed once a fix job exists
  aldc_back u_back (
    .clk, .rst_n,
    .job_valid(qj_valid), .job_ready(qj_ready), .job(qj),
    .train_sum(tsum), .train_sq(tsq), .train_words(tw),
    .threshold(th_r), .duration(du_r), .trained,
    .out_valid(out_tvalid), .out_ready(out_tready), .out_data(res)
  );

  assign out_tdata = {6'h0, res};
endmodule

[tb/tb_audio_level_change_detector_top.sv]
// Testbench for audio_level_change_detector_top: drives word beats, register writes and
// random back-pressure, and checks every result beat against a scoreboard with its own model.
// Depends on aldc_pkg and the top module.
module tb_audio_level_change_detector_top;
  import aldc_pkg::*;

  typedef struct {
    bit        ev;
    bit [31:0] tm;
    bit        tr;
  } level_result_t;

  class level_scoreboard;
    bit [15:0] train_limit;
    bit [19:0] thresh;
    bit [31:0] duration;
    bit trained, in_buffer, buf_trains;
    longint unsigned tsum, tsq, twords, mean, dev, bsum, bwords;
    level_result_t pending_q[$];
    int mismatches, results, events, train_results;

    function new();
      train_limit = 16'd1600;
      thresh = 20'd20795;
      duration = '0;
      trained = 0;
      in_buffer = 0;
      buf_trains = 0;
      tsum = 0; tsq = 0; twords = 0; mean = 0; dev = 0; bsum = 0; bwords = 0;
    endfunction

    function longint unsigned isqrt(longint unsigned v);
      longint unsigned root, cand;
      root = 0;
      for (int b = 31; b >= 0; b--) begin
        cand = root | (64'd1 << b);
        if (cand * cand <= v) root = cand;
      end
      return root;
    endfunction

    function void note_word(bit [15:0] w, bit last_flag, bit [31:0] step, bit [31:0] total);
      level_result_t r;
      longint unsigned m, spread, target, diff, lhs, rhs, q;
      if (!in_buffer) begin
        in_buffer = 1;
        bsum = 0;
        bwords = 0;
        buf_trains = 0;
        if (!trained) begin
          if (twords < train_limit) begin
            buf_trains = 1;
          end else begin
            // freeze statistics from the training words
            if (twords == 0) begin
              mean = 0;
              dev = 0;
            end else begin
              m = tsum / twords;
              spread = tsq + twords * m * m - 2 * m * tsum;
              mean = m & 16'hFFFF;
              dev = isqrt(spread / twords) & 16'hFFFF;
            end
            trained = 1;
          end
        end
      end
      bsum += w;
      bwords++;
      if (buf_trains) begin
        tsum += w;
        tsq += longint'(w) * w;
        twords++;
      end
      if (bwords >= MaxBufferWords) last_flag = 1;
      if (!last_flag) return;
      in_buffer = 0;
      r.ev = 0;
      r.tm = 0;
      if (trained && !buf_trains) begin
        target = mean * bwords;
        diff = (bsum >= target) ? bsum - target : target - bsum;
        lhs = diff << 16;
        rhs = longint'(thresh) * dev * bwords;
        if (lhs > rhs) begin
          r.ev = 1;
          if (total != 0) begin
            q = (longint'(step) * duration) / total;
            r.tm = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
          end
        end
      end
      buf_trains = 0;
      r.tr = trained;
      pending_q.insert(pending_q.size(), r);
    endfunction

    function void check_result(bit [39:0] d);
      level_result_t e;
      results++;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", d);
        return;
      end
      e = pending_q.pop_front();
      if (e.ev) events++;
      if (!e.tr) train_results++;
      if (d[0] !== e.ev || d[32:1] !== e.tm || d[33] !== e.tr || d[39:34] !== '0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d: expected ev=%0b time=%0d trained=%0b, got ev=%0b time=%0d trained=%0b",
                   results, e.ev, e.tm, e.tr, d[0], d[32:1], d[33]);
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [79:0] in_tdata = '0;   // sample_word[15:0], progress_step[47:16], progress_total[79:48]
  logic        in_tlast = 0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [39:0] out_tdata;       // event_detected[0], event_time[32:1], trained[33], zero fill
  logic        cfg_psel = 0;
  logic        cfg_penable = 0;
  logic        cfg_pwrite = 0;
  logic [3:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  level_scoreboard sb = new();
  int tx_idle = 0;
  int rx_idle = 0;
  bit hold_off = 0;
  int words_sent = 0;

  audio_level_change_detector_top dut (.*);

  always #1 clk = ~clk;

  initial begin
    #3_000_000;
    $display("timeout with %0d results outstanding", sb.pending_q.size());
    $display("RESULT: ERROR");
    $finish;
  end

  // receiver: check the beat taken at this edge, then pick the next ready
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
    out_tready <= rst_n && !hold_off && ($urandom_range(99) >= rx_idle);
  end

  task automatic hold_receiver(int cycles);
    hold_off <= 1;
    repeat (cycles) @(posedge clk);
    hold_off <= 0;
  endtask

  task automatic reg_write(logic [1:0] idx, logic [31:0] value);
    cfg_psel <= 1;
    cfg_penable <= 0;
    cfg_pwrite <= 1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    cfg_psel <= 0;
    cfg_penable <= 0;
    cfg_pwrite <= 0;
    case (idx)
      REG_TRAIN:  sb.train_limit = value[15:0];
      REG_THRESH: sb.thresh = value[19:0];
      REG_DUR:    sb.duration = value;
      default: ;
    endcase
  endtask

  task automatic send_word(bit [15:0] w, bit last_flag, bit [31:0] step, bit [31:0] total);
    while ($urandom_range(99) < tx_idle) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= {total, step, w};
    in_tlast <= last_flag;
    do @(posedge clk); while (!in_tready);
    sb.note_word(w, last_flag, step, total);
    words_sent++;
  endtask

  // one buffer of len words drawn from [lo, hi]; close_it=0 leaves tlast low throughout
  task automatic send_buffer(int len, int lo, int hi, bit close_it = 1);
    bit [31:0] total;
    for (int i = 0; i < len; i++) begin
      total = ($urandom_range(7) == 0) ? 32'd0 : $urandom;
      send_word($urandom_range(hi, lo), close_it && (i == len - 1), $urandom, total);
    end
  endtask

  task automatic settle();
    in_tvalid <= 0;
    in_tlast <= 0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic random_phase(int count);
    int start, len, pick, lo, hi;
    start = words_sent;
    while (words_sent - start < count) begin
      pick = $urandom_range(9);
      len = (pick < 7) ? $urandom_range(8, 1) : $urandom_range(40, 9);
      case ($urandom_range(3))
        0: begin lo = 0; hi = 65535; end
        1: begin lo = 0; hi = 15000; end
        2: begin lo = 50000; hi = 65535; end
        default: begin
          lo = sb.mean > 3000 ? int'(sb.mean) - 3000 : 0;
          hi = int'(sb.mean) + 3000;
        end
      endcase
      send_buffer(len, lo, hi);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    tx_idle = 27; rx_idle = 86;
    // training: extremes first, then a spread around mid scale
    reg_write(REG_TRAIN, 32'd16);
    reg_write(REG_DUR, 32'hFFFF_FFFF);
    send_word(16'h0000, 0, 32'd1, 32'd1);
    send_word(16'hFFFF, 1, 32'd1, 32'd1);
    send_buffer(7, 20000, 40000);
    send_buffer(7, 20000, 40000);
    // first tested buffers: extremes, zero total, saturated time
    send_word(16'h0000, 1, 32'hFFFF_FFFF, 32'd1);
    send_word(16'hFFFF, 1, 32'd5, 32'd0);
    send_word(16'd30000, 1, 32'd7, 32'd9);
    send_buffer(3, 0, 65535);
    send_buffer(3, 25000, 35000);
    settle();

    reg_write(REG_THRESH, 32'd0);
    reg_write(REG_DUR, 32'd0);
    random_phase(300);
    settle();
    reg_write(REG_THRESH, 32'hF_FFFF);
    reg_write(REG_DUR, $urandom);
    random_phase(300);
    settle();

    tx_idle = 86; rx_idle = 27;
    reg_write(REG_THRESH, 32'd20795);
    reg_write(REG_TRAIN, 32'd65535);
    reg_write(REG_DUR, 32'd12345);
    random_phase(500);
    settle();

    tx_idle = 0; rx_idle = 0;
    reg_write(REG_THRESH, 32'd4000);
    reg_write(REG_DUR, $urandom);
    fork
      hold_receiver(800);
      random_phase(700);
    join
    settle();

    $display("sent %0d words; checked %0d results, %0d training, %0d events",
             words_sent, sb.results, sb.train_results, sb.events);
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending_q.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
